@@ rtl/growable_stack_with_capacity_core_defines.svh @@
// Assertion macros shared by the growable stack core.
`ifndef GROWABLE_STACK_WITH_CAPACITY_CORE_DEFINES_SVH
`define GROWABLE_STACK_WITH_CAPACITY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define GSWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gswc: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define GSWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gswc: next-cycle check failed");

`endif

@@ rtl/gswc_pkg.sv @@
// Shared types and constants of the growable stack core.
package gswc_pkg;

  localparam int unsigned MaxElementsDef = 64;
  localparam int unsigned QueueDepth     = 2;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CapW    = 8;

  // Request codes on the mode input
  localparam logic [ModeW-1:0] MODE_EMPTY = 3'd0;
  localparam logic [ModeW-1:0] MODE_PUSH  = 3'd1;
  localparam logic [ModeW-1:0] MODE_POP   = 3'd2;
  localparam logic [ModeW-1:0] MODE_FIRST = 3'd3;
  localparam logic [ModeW-1:0] MODE_TOP   = 3'd4;
  localparam logic [ModeW-1:0] MODE_DUMP  = 3'd5;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  // Operation carried from the front to the back
  typedef enum logic [2:0] {
    OP_EMPTY,
    OP_PUSH,
    OP_POP,
    OP_FIRST,
    OP_TOP,
    OP_DUMP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] value;
  } req_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  typedef struct packed {
    logic dumping;
    logic full;
  } back_stat_t;

endpackage

@@ rtl/gswc_front.sv @@
// Front end: classify incoming requests and drop unused modes.
module gswc_front (
  input  logic                             start_i,
  input  logic                             full_i,
  input  logic [gswc_pkg::ModeW-1:0]       mode_i,
  input  logic signed [gswc_pkg::WordW-1:0] push_value_i,
  output logic                             busy_o,
  output logic                             push_o,
  output gswc_pkg::req_t                   req_o
);

  logic        known;
  gswc_pkg::op_e op;

  // Map the mode onto an operation; unused modes produce nothing
  always_comb begin
    known = 1'b1;
    op    = gswc_pkg::OP_EMPTY;
    unique case (mode_i)
      gswc_pkg::MODE_EMPTY: op = gswc_pkg::OP_EMPTY;
      gswc_pkg::MODE_PUSH:  op = gswc_pkg::OP_PUSH;
      gswc_pkg::MODE_POP:   op = gswc_pkg::OP_POP;
      gswc_pkg::MODE_FIRST: op = gswc_pkg::OP_FIRST;
      gswc_pkg::MODE_TOP:   op = gswc_pkg::OP_TOP;
      gswc_pkg::MODE_DUMP:  op = gswc_pkg::OP_DUMP;
      default:              known = 1'b0;
    endcase
  end

  // Hold requests off while the queue is full
  assign busy_o      = full_i;
  assign push_o      = start_i && !full_i && known;
  assign req_o.op    = op;
  assign req_o.value = push_value_i;

endmodule

@@ rtl/gswc_fifo.sv @@
// Short request queue between front and back ends.
module gswc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gswc_pkg::req_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output gswc_pkg::req_t data_o
);

  localparam int unsigned Depth = gswc_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  gswc_pkg::req_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/gswc_back.sv @@
// Back end: element store, count and capacity, result register and dump walker.
module gswc_back #(
  parameter int unsigned MAX_ELEMENTS = gswc_pkg::MaxElementsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  gswc_pkg::req_t                    req_i,
  output logic                              req_pop_o,
  output logic                              valid_o,
  output logic [gswc_pkg::StatusW-1:0]      status_o,
  output logic signed [gswc_pkg::WordW-1:0] data_word_o,
  output logic [gswc_pkg::CapW-1:0]         capacity_now_o,
  output logic                              last_of_run_o,
  output gswc_pkg::back_stat_t              stat_o
);

  localparam int unsigned AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CapW  = gswc_pkg::CapW;
  localparam int unsigned WordW = gswc_pkg::WordW;

  logic [WordW-1:0] mem [MAX_ELEMENTS];
  logic [WordW-1:0] rd_data_q;

  gswc_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CapW-1:0]  cap_q, cap_d;

  logic                      valid_q, valid_d;
  logic [gswc_pkg::StatusW-1:0] status_q, status_d;
  logic                      last_q, last_d;
  logic                      use_mem_q, use_mem_d;
  logic                      flag_q, flag_d;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             is_empty, is_full;
  logic [AddrW-1:0] top_addr;
  logic [CntW-1:0]  idx_next;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(MAX_ELEMENTS));
  assign top_addr = AddrW'(count_q - 1'b1);
  assign wr_addr  = count_q[AddrW-1:0];
  assign idx_next = idx_q + 1'b1;

  // Execute one request, or step the dump walker
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cap_d     = cap_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    last_d    = last_q;
    use_mem_d = use_mem_q;
    flag_d    = flag_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    req_pop_o = 1'b0;
    unique case (state_q)
      gswc_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          valid_d   = 1'b1;
          status_d  = gswc_pkg::STATUS_OK;
          last_d    = 1'b1;
          use_mem_d = 1'b0;
          flag_d    = 1'b0;
          unique case (req_i.op)
            gswc_pkg::OP_EMPTY: begin
              flag_d = is_empty;
            end
            gswc_pkg::OP_PUSH: begin
              if (is_full) begin
                status_d = gswc_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
                // grow when the new count reaches the capacity
                if (CapW'(count_d) >= cap_q) begin
                  cap_d = {cap_q[CapW-2:0], 1'b0};
                end
              end
            end
            gswc_pkg::OP_POP: begin
              if (is_empty) begin
                status_d = gswc_pkg::STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = top_addr;
                use_mem_d = 1'b1;
                count_d   = count_q - 1'b1;
                // shrink when (new count + 1), i.e. the old count, fits in half
                if (CapW'(count_q) <= {1'b0, cap_q[CapW-1:1]}) begin
                  cap_d = {1'b0, cap_q[CapW-1:1]};
                end
              end
            end
            gswc_pkg::OP_FIRST: begin
              if (is_empty) begin
                status_d = gswc_pkg::STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                use_mem_d = 1'b1;
              end
            end
            gswc_pkg::OP_TOP: begin
              if (is_empty) begin
                status_d = gswc_pkg::STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = top_addr;
                use_mem_d = 1'b1;
              end
            end
            gswc_pkg::OP_DUMP: begin
              if (is_empty) begin
                status_d = gswc_pkg::STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                use_mem_d = 1'b1;
                if (count_q != CntW'(1)) begin
                  last_d  = 1'b0;
                  idx_d   = CntW'(1);
                  state_d = gswc_pkg::ST_DUMP;
                end
              end
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      gswc_pkg::ST_DUMP: begin
        valid_d   = 1'b1;
        status_d  = gswc_pkg::STATUS_OK;
        rd_en     = 1'b1;
        rd_addr   = idx_q[AddrW-1:0];
        use_mem_d = 1'b1;
        last_d    = (idx_next == count_q);
        idx_d     = idx_next;
        if (idx_next == count_q) begin
          state_d = gswc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gswc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gswc_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      cap_q   <= CapW'(1);
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      cap_q   <= cap_d;
      valid_q <= valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    last_q    <= last_d;
    use_mem_q <= use_mem_d;
    flag_q    <= flag_d;
  end

  // Element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign data_word_o    = use_mem_q ? rd_data_q : {{(WordW-1){1'b0}}, flag_q};
  assign capacity_now_o = cap_q;
  assign last_of_run_o  = last_q;
  assign stat_o.dumping = (state_q == gswc_pkg::ST_DUMP);
  assign stat_o.full    = is_full;

endmodule

@@ rtl/growable_stack_with_capacity_core.sv @@
// Top level of the growable stack core: front end, request queue, back end.
//
//  channel   direction  handshake          payload
//  request   in         start / busy       mode_i, push_value_i
//  result    out        valid_o strobe     status_o, data_word_o, capacity_now_o,
//                                          last_of_run_o
//
// A request is written into the queue at the accepting edge; the back end then takes
// it from the queue head, and its result passes through the result register.
// Push, pop and the queries each run in the back end's idle state; a dump walks the
// element store through its single read port, one element per cycle.
// busy rises while the two-entry queue is full. Modes 6 and 7 give no result.
// Reset empties the stack and sets the capacity to one; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "growable_stack_with_capacity_core_defines.svh"

module growable_stack_with_capacity_core #(
  parameter int unsigned MAX_ELEMENTS = gswc_pkg::MaxElementsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [gswc_pkg::ModeW-1:0]        mode_i,
  input  logic signed [gswc_pkg::WordW-1:0] push_value_i,
  output logic                              valid_o,
  output logic [gswc_pkg::StatusW-1:0]      status_o,
  output logic signed [gswc_pkg::WordW-1:0] data_word_o,
  output logic [gswc_pkg::CapW-1:0]         capacity_now_o,
  output logic                              last_of_run_o
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  gswc_pkg::req_t       front_req;
  gswc_pkg::req_t       back_req;
  gswc_pkg::back_stat_t stat;

  // Classify incoming requests
  gswc_front u_front (
    .start_i      (start),
    .full_i       (q_full),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .busy_o       (busy),
    .push_o       (q_push),
    .req_o        (front_req)
  );

  // Decouple front and back
  gswc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_req),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (back_req)
  );

  // Carry out requests on the stack
  gswc_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (q_valid),
    .req_i          (back_req),
    .req_pop_o      (q_pop),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .data_word_o    (data_word_o),
    .capacity_now_o (capacity_now_o),
    .last_of_run_o  (last_of_run_o),
    .stat_o         (stat)
  );

  // A dropped push only happens with the store at its limit
  `GSWC_ASSERT_IMP(a_full_drop, valid_o && (status_o == gswc_pkg::STATUS_FULL), stat.full)
  // The dump walker emits a result on every cycle it runs
  `GSWC_ASSERT_NXT(a_dump_emits, stat.dumping, valid_o)
  // A result that is not the last of its run belongs to a running dump
  `GSWC_ASSERT_IMP(a_run_open, valid_o && !last_of_run_o, stat.dumping)
  // Capacity never collapses to zero
  `GSWC_ASSERT_IMP(a_cap_nonzero, valid_o, capacity_now_o != '0)

endmodule
